FILE: design/pdsr_pkg.sv
// Shared types, constants and sine table for the pi/4 DQPSK symbol recovery block.
package pdsr_pkg;

  localparam int unsigned SineEntriesDefault = 256;
  localparam logic [31:0] StepMin   = 32'd1600000000;
  localparam logic [31:0] StepMax   = 32'd1620000000;
  localparam logic [31:0] FreqLimit = 32'd400000000;
  localparam logic [31:0] HalfTurn  = 32'h80000000;
  localparam logic [30:0] StepStartReset = 31'd1610612736;
  localparam logic [7:0]  GainPhaseReset = 8'd32;
  localparam logic [7:0]  GainFreqReset  = 8'd1;

  localparam logic [1:0] RegGainPhase = 2'd0;
  localparam logic [1:0] RegGainFreq  = 2'd1;
  localparam logic [1:0] RegStepStart = 2'd2;

  localparam logic [1:0] DibitQ1 = 2'b00;
  localparam logic [1:0] DibitQ2 = 2'b01;
  localparam logic [1:0] DibitQ3 = 2'b11;
  localparam logic [1:0] DibitQ4 = 2'b10;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_NCO,
    S_TE0, S_TE1, S_DI0, S_DI1, S_DQ0, S_DQ1, S_DEC, S_PLL0, S_PLL1, S_OUT
  } state_t;

  function automatic logic [6:0] quarter_sine(input logic [6:0] r);
    logic [6:0] v;
    case (r)
      7'd0: v = 7'd0;     7'd1: v = 7'd3;     7'd2: v = 7'd6;     7'd3: v = 7'd9;
      7'd4: v = 7'd12;    7'd5: v = 7'd16;    7'd6: v = 7'd19;    7'd7: v = 7'd22;
      7'd8: v = 7'd25;    7'd9: v = 7'd28;    7'd10: v = 7'd31;   7'd11: v = 7'd34;
      7'd12: v = 7'd37;   7'd13: v = 7'd40;   7'd14: v = 7'd43;   7'd15: v = 7'd46;
      7'd16: v = 7'd49;   7'd17: v = 7'd51;   7'd18: v = 7'd54;   7'd19: v = 7'd57;
      7'd20: v = 7'd60;   7'd21: v = 7'd63;   7'd22: v = 7'd65;   7'd23: v = 7'd68;
      7'd24: v = 7'd71;   7'd25: v = 7'd73;   7'd26: v = 7'd76;   7'd27: v = 7'd78;
      7'd28: v = 7'd81;   7'd29: v = 7'd83;   7'd30: v = 7'd85;   7'd31: v = 7'd88;
      7'd32: v = 7'd90;   7'd33: v = 7'd92;   7'd34: v = 7'd94;   7'd35: v = 7'd96;
      7'd36: v = 7'd98;   7'd37: v = 7'd100;  7'd38: v = 7'd102;  7'd39: v = 7'd104;
      7'd40: v = 7'd106;  7'd41: v = 7'd107;  7'd42: v = 7'd109;  7'd43: v = 7'd111;
      7'd44: v = 7'd112;  7'd45: v = 7'd113;  7'd46: v = 7'd115;  7'd47: v = 7'd116;
      7'd48: v = 7'd117;  7'd49: v = 7'd118;  7'd50: v = 7'd120;  7'd51: v = 7'd121;
      7'd52: v = 7'd122;  7'd53: v = 7'd122;  7'd54: v = 7'd123;  7'd55: v = 7'd124;
      7'd56: v = 7'd125;  7'd57: v = 7'd125;  7'd58: v = 7'd126;  7'd59: v = 7'd126;
      7'd60: v = 7'd126;  7'd61: v = 7'd127;  7'd62: v = 7'd127;  7'd63: v = 7'd127;
      default: v = 7'd127;
    endcase
    return v;
  endfunction

endpackage

FILE: design/pdsr_if.sv
// Valid/ready stream interfaces for samples, symbols and register writes.
interface pdsr_sample_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample_real;
  logic signed [15:0] sample_imag;
  modport source (output valid, sample_real, sample_imag, input ready);
  modport sink   (input valid, sample_real, sample_imag, output ready);
endinterface

interface pdsr_symbol_if;
  logic               valid;
  logic               ready;
  logic [1:0]         dibit;
  logic signed [31:0] diff_real;
  logic signed [31:0] diff_imag;
  modport source (output valid, dibit, diff_real, diff_imag, input ready);
  modport sink   (input valid, dibit, diff_real, diff_imag, output ready);
endinterface

interface pdsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/pi4_dqpsk_symbol_recovery.sv
// Top level: carrier derotation, Gardner timing and differential symbol decision.
// One sample is taken at a time. A sample that does not complete a symbol
// drops ready while it passes through the rotation states and the NCO
// update. A sample that completes a symbol goes on through the timing error,
// differential product, decision and loop update states before it presents
// its result, and the next sample is taken the cycle after that result has
// been requested. All products run through one shared 32x32 multiplier, one
// product per cycle, stepped by a small sequencer. Register writes are accepted
// only while the block is idle and take effect at once.
module pi4_dqpsk_symbol_recovery #(
  parameter int unsigned SINE_ENTRIES = pdsr_pkg::SineEntriesDefault
) (
  input logic clk,
  input logic rst,
  pdsr_sample_if.sink   samples,
  pdsr_symbol_if.source symbols,
  pdsr_cfg_if.sink      cfg
);
  import pdsr_pkg::*;

  localparam int unsigned IdxW = $clog2(SINE_ENTRIES);
  localparam int unsigned QtrW = IdxW - 2;

  state_t state, state_next;

  logic [7:0]  gain_phase, gain_freq;
  logic [31:0] carrier_phase, carrier_freq, sym_acc, sym_step;
  logic [31:0] mid_pt, prompt_pt, last_prompt;
  logic [15:0] in_re, in_im;
  logic [31:0] sin_v, cos_v, acc, prod_r, di, dq, pe;
  logic [15:0] rot_re;
  logic [1:0]  dibit_r;
  logic        out_valid;

  // sine lookup
  function automatic logic [31:0] sine_at(input logic [IdxW-1:0] idx);
    logic [1:0]      q;
    logic [QtrW-1:0] r;
    logic [6:0]      mag;
    logic [QtrW:0]   ri;
    q  = idx[IdxW-1 -: 2];
    r  = idx[QtrW-1:0];
    ri = q[0] ? ((QtrW+1)'(SINE_ENTRIES/4) - {1'b0, r}) : {1'b0, r};
    mag = quarter_sine(7'(ri));
    return q[1] ? -{25'd0, mag} : {25'd0, mag};
  endfunction

  logic [IdxW-1:0] sidx;
  assign sidx = carrier_phase[31 -: IdxW];
  assign sin_v = sine_at(sidx);
  assign cos_v = sine_at(sidx + IdxW'(SINE_ENTRIES/4));

  function automatic logic [31:0] sx(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // shared multiplier operands
  logic [31:0] ma, mb, mp;
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_ROT0: begin ma = sx(in_re); mb = cos_v; end
      S_ROT1: begin ma = sx(in_im); mb = sin_v; end
      S_ROT2: begin ma = sx(in_re); mb = sin_v; end
      S_ROT3: begin ma = sx(in_im); mb = cos_v; end
      S_TE0: begin
        ma = sx(mid_pt[15:0]);
        mb = sx(prompt_pt[15:0]) - sx(last_prompt[15:0]);
      end
      S_TE1: begin
        ma = sx(mid_pt[31:16]);
        mb = sx(prompt_pt[31:16]) - sx(last_prompt[31:16]);
      end
      S_DI0: begin ma = sx(prompt_pt[15:0]);  mb = sx(last_prompt[15:0]); end
      S_DI1: begin ma = sx(prompt_pt[31:16]); mb = sx(last_prompt[31:16]); end
      S_DQ0: begin ma = sx(prompt_pt[31:16]); mb = sx(last_prompt[15:0]); end
      S_DQ1: begin ma = sx(prompt_pt[15:0]);  mb = sx(last_prompt[31:16]); end
      S_PLL0: begin ma = pe; mb = {24'd0, gain_freq}; end
      S_PLL1: begin ma = pe; mb = {24'd0, gain_phase}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mp = 32'(ma * mb);

  // derived values
  logic [31:0] rot_im_full, sym_new, te, step_adj;
  logic [15:0] rot_im;
  logic signed [32:0] step_sum, freq_sum;
  logic [31:0] freq_clamped;
  logic        wrap, mid_hit;
  assign rot_im_full = acc + mp;
  assign rot_im = 16'($signed(rot_im_full) >>> 7);
  assign sym_new = sym_acc + sym_step;
  assign wrap = sym_new < sym_acc;
  assign mid_hit = (sym_acc < HalfTurn) && (sym_new >= HalfTurn);
  assign te = acc + mp;
  assign step_adj = 32'($signed(te) >>> 16);
  assign step_sum = $signed({1'b0, sym_step}) + $signed({step_adj[31], step_adj});
  assign freq_sum = $signed({carrier_freq[31], carrier_freq})
                  + $signed({prod_r[31], prod_r});

  always_comb begin
    if (freq_sum > $signed({1'b0, FreqLimit}))
      freq_clamped = FreqLimit;
    else if (freq_sum < -$signed({1'b0, FreqLimit}))
      freq_clamped = -FreqLimit;
    else
      freq_clamped = freq_sum[31:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (samples.valid) state_next = S_ROT0;
      S_ROT0: state_next = S_ROT1;
      S_ROT1: state_next = S_ROT2;
      S_ROT2: state_next = S_ROT3;
      S_ROT3: state_next = S_NCO;
      S_NCO:  state_next = wrap ? S_TE0 : S_IDLE;
      S_TE0:  state_next = S_TE1;
      S_TE1:  state_next = S_DI0;
      S_DI0:  state_next = S_DI1;
      S_DI1:  state_next = S_DQ0;
      S_DQ0:  state_next = S_DQ1;
      S_DQ1:  state_next = S_DEC;
      S_DEC:  state_next = S_PLL0;
      S_PLL0: state_next = S_PLL1;
      S_PLL1: state_next = S_OUT;
      S_OUT:  if (symbols.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign samples.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign symbols.valid = out_valid;
  assign symbols.dibit = dibit_r;
  assign symbols.diff_real = di;
  assign symbols.diff_imag = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gain_phase <= GainPhaseReset;
      gain_freq <= GainFreqReset;
      carrier_phase <= '0;
      carrier_freq <= '0;
      sym_acc <= '0;
      sym_step <= {1'b0, StepStartReset};
      mid_pt <= '0;
      prompt_pt <= '0;
      last_prompt <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          in_re <= samples.sample_real;
          in_im <= samples.sample_imag;
        end
        S_ROT0: acc <= mp;
        S_ROT1: rot_re <= 16'($signed(acc - mp) >>> 7);
        S_ROT2: acc <= mp;
        S_ROT3: acc <= acc + mp;
        S_NCO: begin
          sym_acc <= sym_new;
          if (mid_hit) mid_pt <= {rot_im, rot_re};
          if (wrap) begin
            last_prompt <= prompt_pt;
            prompt_pt <= {rot_im, rot_re};
          end
        end
        S_TE0: acc <= mp;
        S_TE1: begin
          if (step_sum < $signed({1'b0, StepMin})) sym_step <= StepMin;
          else if (step_sum > $signed({1'b0, StepMax})) sym_step <= StepMax;
          else sym_step <= step_sum[31:0];
        end
        S_DI0: acc <= mp;
        S_DI1: di <= acc + mp;
        S_DQ0: acc <= mp;
        S_DQ1: dq <= acc - mp;
        S_DEC: begin
          if (!di[31] && di != 0 && !dq[31] && dq != 0) begin
            pe <= dq - di; dibit_r <= DibitQ1;
          end else if (di[31] && !dq[31] && dq != 0) begin
            pe <= dq + di; dibit_r <= DibitQ2;
          end else if (di[31] && dq[31]) begin
            pe <= di - dq; dibit_r <= DibitQ3;
          end else begin
            pe <= 32'd0 - dq - di; dibit_r <= DibitQ4;
          end
        end
        S_PLL0: prod_r <= 32'($signed(mp) >>> 8);
        S_PLL1: begin
          carrier_freq <= freq_clamped;
          carrier_phase <= carrier_phase + 32'($signed(mp) >>> 8) + freq_clamped;
        end
        default: ;
      endcase
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          RegGainPhase: gain_phase <= cfg.data[7:0];
          RegGainFreq:  gain_freq <= cfg.data[7:0];
          RegStepStart: sym_step <= {1'b0, cfg.data};
          default: ;
        endcase
      end
    end
  end
endmodule
